// ===== hw/rtl/phase_locked_vocoder_phase_core_assert.svh =====
// assertion macros for the phase vocoder phase core
// no dependencies; included by the modules that assert
`ifndef PHASE_LOCKED_VOCODER_PHASE_CORE_ASSERT_SVH
`define PHASE_LOCKED_VOCODER_PHASE_CORE_ASSERT_SVH

// same-cycle implication, reset masks the check
`define PVP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pvp assertion failed");

// next-cycle implication
`define PVP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pvp assertion failed");

`endif

// ===== hw/rtl/pvp_pkg.sv =====
// shared types and constants of the phase vocoder phase core
// no dependencies
package pvp_pkg;

  localparam int BIN_W      = 14;
  localparam int MAG_W      = 24;
  localparam int PH_W       = 16;
  localparam int HOP_W      = 15;
  localparam int GAIN_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int INST_W     = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_HOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd2;

  localparam logic [HOP_W-1:0]  HOP_RST    = 15'd512;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 32'd65536;
  localparam logic [BIN_W-1:0]  CUTOFF_RST = 14'd8192;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_ISSUE,
    S_EMIT,
    S_PK_RD,
    S_PK_CHK,
    S_MP_I0,
    S_MP_I1,
    S_MP_I2,
    S_MP_ID,
    S_MP_STEP,
    S_MP_WAIT,
    S_OM_RD,
    S_OM_GO,
    S_OM_WAIT,
    S_SY_A,
    S_SY_B,
    S_SY_C,
    S_CP_RD,
    S_CP_WR
  } pvp_state_e;

endpackage

// ===== hw/rtl/pvp_omega_mul.sv =====
// serial 48x32 multiplier for the scaled instantaneous frequency
// uses pvp_pkg widths; one 16x32 partial product per cycle
module pvp_omega_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pvp_pkg::INST_W-1:0]   inst_i,
  input  logic [pvp_pkg::GAIN_W-1:0]   gain_i,
  output logic                         done_o,
  output logic [pvp_pkg::PH_W-1:0]     omega_o
);

  localparam logic [pvp_pkg::INST_W-1:0] ACC_INIT = 48'h0000_8000_0000;

  logic                        busy_q;
  logic                        done_q;
  logic [1:0]                  step_q;
  logic [pvp_pkg::INST_W-1:0]  op_q;
  logic [pvp_pkg::INST_W-1:0]  acc_q;
  logic [pvp_pkg::INST_W-1:0]  pp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // product is kept modulo 2^48, only bits 47:32 are used
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q  <= inst_i;
      acc_q <= ACC_INIT;
    end else if (busy_q) begin
      pp_q <= pvp_pkg::INST_W'(op_q[15:0] * gain_i);
      op_q <= op_q >> 16;
      case (step_q)
        2'd1:    acc_q <= acc_q + pp_q;
        2'd2:    acc_q <= acc_q + (pp_q << 16);
        2'd3:    acc_q <= acc_q + (pp_q << 32);
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign done_o  = done_q;
  assign omega_o = acc_q[47:32];

endmodule

// ===== hw/rtl/phase_locked_vocoder_phase_core.sv =====
// top level of the peak-locked phase vocoder phase core
// uses pvp_pkg, pvp_omega_mul and the assertion macro header
//
// A read or a channel-1 load passes through accept, memory read and result
// register steps and waits further while the previous result is not taken.
// The item marked last on channel 0 closes the frame of n bins and the block
// stalls input through a peak search over the magnitude memory, a nearest-peak
// walk, omega (one shared 16x32 multiplier used three times per bin), synthesis
// (skipped on a transient) and a copy, all sequential memory walks. After reset
// a clearing pass over all FFT_SIZE/2+1 bins zeroes the previous and synthesis
// phase memories before the first request is taken.
module phase_locked_vocoder_phase_core #(
  parameter int FFT_SIZE     = 16384,
  parameter int NUM_CHANNELS = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cmd_i,
  input  logic                             channel_i,
  input  logic [pvp_pkg::BIN_W-1:0]        bin_index_i,
  input  logic [pvp_pkg::MAG_W-1:0]        magnitude_i,
  input  logic [pvp_pkg::PH_W-1:0]         phase_i,
  input  logic                             transient_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pvp_pkg::BIN_W-1:0]        out_bin_o,
  output logic [pvp_pkg::MAG_W-1:0]        out_magnitude_o,
  output logic [pvp_pkg::PH_W-1:0]         out_phase_o,
  output logic                             out_channel_o,
  input  logic                             cfg_we_i,
  input  logic [pvp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pvp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  `include "phase_locked_vocoder_phase_core_assert.svh"

  localparam int NBINS    = FFT_SIZE / 2 + 1;
  localparam int AW       = $clog2(NBINS);
  localparam int CW       = $clog2(NBINS + 1);
  localparam int LOG2_FFT = $clog2(FFT_SIZE);
  localparam int EX_SH    = 32 - LOG2_FFT;
  localparam logic [CW-1:0] NBINS_C = CW'(NBINS);

  localparam int PH_W  = pvp_pkg::PH_W;
  localparam int MAG_W = pvp_pkg::MAG_W;
  localparam int IW    = pvp_pkg::INST_W;

  // configuration
  logic [pvp_pkg::HOP_W-1:0]  hop_q;
  logic [pvp_pkg::GAIN_W-1:0] gain_q;
  logic [pvp_pkg::BIN_W-1:0]  cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_q    <= pvp_pkg::HOP_RST;
      gain_q   <= pvp_pkg::GAIN_RST;
      cutoff_q <= pvp_pkg::CUTOFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pvp_pkg::CFG_HOP:    hop_q    <= cfg_data_i[pvp_pkg::HOP_W-1:0];
        pvp_pkg::CFG_GAIN:   gain_q   <= cfg_data_i;
        pvp_pkg::CFG_CUTOFF: cutoff_q <= cfg_data_i[pvp_pkg::BIN_W-1:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [MAG_W-1:0] mag_mem   [NBINS];
  logic [PH_W-1:0]  cur_mem   [NBINS];
  logic [PH_W-1:0]  prev_mem  [NBINS];
  logic [PH_W-1:0]  syn_mem   [NBINS];
  logic [AW-1:0]    npm_mem   [NBINS];
  logic [AW-1:0]    pk_mem    [NBINS];
  logic [PH_W-1:0]  om_mem    [NBINS];
  logic [PH_W-1:0]  psi_mem   [NBINS];

  logic [AW-1:0] mag_ra, cur_ra0, cur_ra1, prev_ra, syn_ra, npm_ra, pk_ra, om_ra, psi_ra;
  logic [MAG_W-1:0] mag_rd_q;
  logic [PH_W-1:0]  cur_rd0_q, cur_rd1_q, prev_rd_q, syn_rd_q, om_rd_q, psi_rd_q;
  logic [AW-1:0]    npm_rd_q, pk_rd_q;

  logic             cur_we, syn_we, prev_we, npm_we, pk_we, om_we, psi_we;
  logic [AW-1:0]    cur_wa, syn_wa, prev_wa, npm_wa, pk_wa, om_wa, psi_wa;
  logic [PH_W-1:0]  syn_wd, prev_wd, om_wd, psi_wd;
  logic [AW-1:0]    npm_wd, pk_wd;

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      mag_mem[cur_wa] <= magnitude_i;
      cur_mem[cur_wa] <= phase_i;
    end
    if (syn_we)  syn_mem[syn_wa]   <= syn_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (npm_we)  npm_mem[npm_wa]   <= npm_wd;
    if (pk_we)   pk_mem[pk_wa]     <= pk_wd;
    if (om_we)   om_mem[om_wa]     <= om_wd;
    if (psi_we)  psi_mem[psi_wa]   <= psi_wd;
    mag_rd_q  <= mag_mem[mag_ra];
    cur_rd0_q <= cur_mem[cur_ra0];
    cur_rd1_q <= cur_mem[cur_ra1];
    prev_rd_q <= prev_mem[prev_ra];
    syn_rd_q  <= syn_mem[syn_ra];
    npm_rd_q  <= npm_mem[npm_ra];
    pk_rd_q   <= pk_mem[pk_ra];
    om_rd_q   <= om_mem[om_ra];
    psi_rd_q  <= psi_mem[psi_ra];
  end

  // control state
  pvp_pkg::pvp_state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW-1:0]   pcnt_q, pcnt_d;
  logic [CW-1:0]   k_q, k_d;
  logic            trans_q, trans_d;
  logic            out_valid_q, out_valid_d;

  // payload registers
  logic [AW-1:0]    it_addr_q, it_addr_d;
  logic             it_read_q, it_read_d;
  logic             it_ch_q, it_ch_d;
  logic [MAG_W-1:0] it_mag_q, it_mag_d;
  logic [PH_W-1:0]  it_ph_q, it_ph_d;
  logic [MAG_W-1:0] m1_q, m1_d, m2_q, m2_d;
  logic [AW-1:0]    pa_q, pa_d, pb_q, pb_d;
  logic [IW-1:0]    ex_q, ex_d;
  logic [pvp_pkg::BIN_W-1:0] ob_q, ob_d;
  logic [MAG_W-1:0] om_q, om_d;
  logic [PH_W-1:0]  op_q, op_d;
  logic             oc_q, oc_d;

  logic            accept, out_free, ch_ok, cnt_full;
  logic [CW-1:0]   cnt_inc, idx_inc, k_plus2, dist_a, dist_b;
  logic            idx_last, step_move;
  logic [PH_W-1:0] dph;
  logic [31:0]     dv;
  logic [IW-1:0]   inst, ex_step;
  logic            mul_start, mul_done;
  logic [PH_W-1:0] mul_omega;

  assign accept   = in_valid_i && (state_q == pvp_pkg::S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign ch_ok    = int'(channel_i) < NUM_CHANNELS;
  assign cnt_full = cnt_q >= NBINS_C;
  assign cnt_inc  = cnt_q + CW'(1);
  assign idx_inc  = idx_q + CW'(1);
  assign idx_last = idx_inc == n_q;
  assign k_plus2  = k_q + CW'(2);
  assign dist_a   = (idx_q > CW'(pa_q)) ? idx_q - CW'(pa_q) : CW'(pa_q) - idx_q;
  assign dist_b   = (idx_q > CW'(pb_q)) ? idx_q - CW'(pb_q) : CW'(pb_q) - idx_q;
  assign step_move = (k_q + CW'(1) < pcnt_q) && (dist_b < dist_a);

  // phase advance unwrapped around the expected advance
  assign dph     = cur_rd0_q - prev_rd_q;
  assign dv      = {dph, 16'h0000} - ex_q[31:0];
  assign inst    = ex_q + {{(IW-32){dv[31]}}, dv};
  assign ex_step = IW'(hop_q) << EX_SH;

  pvp_omega_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .inst_i  (inst),
    .gain_i  (gain_q),
    .done_o  (mul_done),
    .omega_o (mul_omega)
  );

  always_comb begin
    logic [AW-1:0] base;
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    n_d         = n_q;
    pcnt_d      = pcnt_q;
    k_d         = k_q;
    trans_d     = trans_q;
    out_valid_d = out_valid_q;
    it_addr_d   = it_addr_q;
    it_read_d   = it_read_q;
    it_ch_d     = it_ch_q;
    it_mag_d    = it_mag_q;
    it_ph_d     = it_ph_q;
    m1_d        = m1_q;
    m2_d        = m2_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    ex_d        = ex_q;
    ob_d        = ob_q;
    om_d        = om_q;
    op_d        = op_q;
    oc_d        = oc_q;
    mul_start   = 1'b0;

    base = (state_q == pvp_pkg::S_ISSUE || state_q == pvp_pkg::S_EMIT) ?
           it_addr_q : idx_q[AW-1:0];
    mag_ra  = base;
    cur_ra0 = base;
    cur_ra1 = base;
    prev_ra = base;
    syn_ra  = base;
    npm_ra  = base;
    om_ra   = base;
    psi_ra  = base;
    pk_ra   = base;

    cur_we  = 1'b0;
    cur_wa  = cnt_q[AW-1:0];
    syn_we  = 1'b0;
    syn_wa  = idx_q[AW-1:0];
    syn_wd  = '0;
    prev_we = 1'b0;
    prev_wa = idx_q[AW-1:0];
    prev_wd = '0;
    npm_we  = 1'b0;
    npm_wa  = idx_q[AW-1:0];
    npm_wd  = pa_q;
    pk_we   = 1'b0;
    pk_wa   = pcnt_q[AW-1:0];
    pk_wd   = AW'(idx_q - CW'(1));
    om_we   = 1'b0;
    om_wa   = idx_q[AW-1:0];
    om_wd   = mul_omega;
    psi_we  = 1'b0;
    psi_wa  = idx_q[AW-1:0];
    psi_wd  = syn_rd_q + om_rd_q + cur_rd0_q - cur_rd1_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      pvp_pkg::S_CLR: begin
        syn_we  = 1'b1;
        prev_we = 1'b1;
        idx_d   = idx_inc;
        if (idx_inc == NBINS_C) begin
          idx_d   = '0;
          state_d = pvp_pkg::S_IDLE;
        end
      end
      pvp_pkg::S_IDLE: begin
        if (accept) begin
          it_mag_d = magnitude_i;
          it_ph_d  = phase_i;
          it_ch_d  = channel_i;
          if (cmd_i == pvp_pkg::CMD_READ) begin
            it_read_d = 1'b1;
            it_addr_d = AW'(bin_index_i);
            if (32'(bin_index_i) < 32'(NBINS)) state_d = pvp_pkg::S_ISSUE;
          end else if (ch_ok && !channel_i) begin
            cur_we = !cnt_full;
            if (!cnt_full) cnt_d = cnt_inc;
            if (last_i) begin
              n_d     = cnt_full ? cnt_q : cnt_inc;
              cnt_d   = '0;
              trans_d = transient_i;
              idx_d   = '0;
              pcnt_d  = '0;
              state_d = pvp_pkg::S_PK_RD;
            end
          end else if (ch_ok) begin
            it_read_d = 1'b0;
            it_addr_d = cnt_q[AW-1:0];
            if (!cnt_full) begin
              cnt_d   = cnt_inc;
              state_d = pvp_pkg::S_ISSUE;
            end
            if (last_i) cnt_d = '0;
          end
        end
      end
      pvp_pkg::S_ISSUE: state_d = pvp_pkg::S_EMIT;
      pvp_pkg::S_EMIT: begin
        if (out_free) begin
          ob_d        = pvp_pkg::BIN_W'(it_addr_q);
          out_valid_d = 1'b1;
          if (it_read_q) begin
            om_d = (32'(it_addr_q) > 32'(cutoff_q)) ? '0 : mag_rd_q;
            op_d = syn_rd_q;
            oc_d = 1'b0;
          end else begin
            om_d = (32'(it_addr_q) > 32'(cutoff_q)) ? '0 : it_mag_q;
            op_d = syn_rd_q + it_ph_q - cur_rd0_q;
            oc_d = it_ch_q;
          end
          state_d = pvp_pkg::S_IDLE;
        end
      end
      pvp_pkg::S_PK_RD: state_d = pvp_pkg::S_PK_CHK;
      pvp_pkg::S_PK_CHK: begin
        // bin idx-1 is a peak when above both neighbors
        if (idx_q >= CW'(2) && m1_q > m2_q && m1_q > mag_rd_q) begin
          pk_we  = 1'b1;
          pcnt_d = pcnt_q + CW'(1);
        end
        m2_d = m1_q;
        m1_d = mag_rd_q;
        if (idx_last) begin
          idx_d   = '0;
          state_d = pvp_pkg::S_MP_I0;
        end else begin
          idx_d   = idx_inc;
          state_d = pvp_pkg::S_PK_RD;
        end
      end
      pvp_pkg::S_MP_I0: begin
        pk_ra   = '0;
        k_d     = '0;
        state_d = (pcnt_q == '0) ? pvp_pkg::S_MP_ID : pvp_pkg::S_MP_I1;
      end
      pvp_pkg::S_MP_I1: begin
        pa_d    = pk_rd_q;
        pk_ra   = AW'(1);
        state_d = pvp_pkg::S_MP_I2;
      end
      pvp_pkg::S_MP_I2: begin
        pb_d    = pk_rd_q;
        state_d = pvp_pkg::S_MP_STEP;
      end
      pvp_pkg::S_MP_ID: begin
        // no peaks: each bin locks to itself
        npm_we = 1'b1;
        npm_wd = idx_q[AW-1:0];
        idx_d  = idx_inc;
        if (idx_last) begin
          idx_d   = '0;
          ex_d    = '0;
          state_d = pvp_pkg::S_OM_RD;
        end
      end
      pvp_pkg::S_MP_STEP: begin
        pk_ra = k_plus2[AW-1:0];
        if (step_move) begin
          k_d     = k_q + CW'(1);
          pa_d    = pb_q;
          state_d = pvp_pkg::S_MP_WAIT;
        end else begin
          npm_we = 1'b1;
          idx_d  = idx_inc;
          if (idx_last) begin
            idx_d   = '0;
            ex_d    = '0;
            state_d = pvp_pkg::S_OM_RD;
          end
        end
      end
      pvp_pkg::S_MP_WAIT: begin
        pb_d    = pk_rd_q;
        state_d = pvp_pkg::S_MP_STEP;
      end
      pvp_pkg::S_OM_RD: state_d = pvp_pkg::S_OM_GO;
      pvp_pkg::S_OM_GO: begin
        mul_start = 1'b1;
        state_d   = pvp_pkg::S_OM_WAIT;
      end
      pvp_pkg::S_OM_WAIT: begin
        if (mul_done) begin
          om_we = 1'b1;
          ex_d  = ex_q + ex_step;
          idx_d = idx_inc;
          state_d = pvp_pkg::S_OM_RD;
          if (idx_last) begin
            idx_d   = '0;
            state_d = trans_q ? pvp_pkg::S_CP_RD : pvp_pkg::S_SY_A;
          end
        end
      end
      pvp_pkg::S_SY_A: state_d = pvp_pkg::S_SY_B;
      pvp_pkg::S_SY_B: begin
        syn_ra  = npm_rd_q;
        om_ra   = npm_rd_q;
        cur_ra1 = npm_rd_q;
        state_d = pvp_pkg::S_SY_C;
      end
      pvp_pkg::S_SY_C: begin
        psi_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = pvp_pkg::S_SY_A;
        if (idx_last) begin
          idx_d   = '0;
          state_d = pvp_pkg::S_CP_RD;
        end
      end
      pvp_pkg::S_CP_RD: state_d = pvp_pkg::S_CP_WR;
      pvp_pkg::S_CP_WR: begin
        syn_we  = 1'b1;
        syn_wd  = trans_q ? cur_rd0_q : psi_rd_q;
        prev_we = 1'b1;
        prev_wd = cur_rd0_q;
        idx_d   = idx_inc;
        state_d = pvp_pkg::S_CP_RD;
        if (idx_last) begin
          idx_d   = '0;
          state_d = pvp_pkg::S_IDLE;
        end
      end
      default: state_d = pvp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pvp_pkg::S_CLR;
      cnt_q       <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      pcnt_q      <= '0;
      k_q         <= '0;
      trans_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      pcnt_q      <= pcnt_d;
      k_q         <= k_d;
      trans_q     <= trans_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_addr_q <= it_addr_d;
    it_read_q <= it_read_d;
    it_ch_q   <= it_ch_d;
    it_mag_q  <= it_mag_d;
    it_ph_q   <= it_ph_d;
    m1_q      <= m1_d;
    m2_q      <= m2_d;
    pa_q      <= pa_d;
    pb_q      <= pb_d;
    ex_q      <= ex_d;
    ob_q      <= ob_d;
    om_q      <= om_d;
    op_q      <= op_d;
    oc_q      <= oc_d;
  end

  assign in_stall_o      = state_q != pvp_pkg::S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign out_bin_o       = ob_q;
  assign out_magnitude_o = om_q;
  assign out_phase_o     = op_q;
  assign out_channel_o   = oc_q;

  // the multiplier only answers while the sequencer waits for it
  `PVP_ASSERT_NOW(a_mul_done_in_wait, mul_done, state_q == pvp_pkg::S_OM_WAIT)
  // a peak list never holds more entries than bins walked
  `PVP_ASSERT_NOW(a_pcnt_bound, state_q == pvp_pkg::S_PK_CHK, pcnt_q <= idx_q)
  // a read in range moves to the memory read step
  `PVP_ASSERT_NEXT(a_read_issue, accept && cmd_i == pvp_pkg::CMD_READ &&
                   32'(bin_index_i) < 32'(NBINS), state_q == pvp_pkg::S_ISSUE)

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of the peak-locked phase vocoder phase core
// depends on pvp_pkg and phase_locked_vocoder_phase_core; holds its own frame predictor
module testbench;

  localparam int NBINS = 16384 / 2 + 1;

  typedef struct packed {
    logic                         cmd;
    logic                         channel;
    logic [pvp_pkg::BIN_W-1:0]    bin_index;
    logic [pvp_pkg::MAG_W-1:0]    magnitude;
    logic [pvp_pkg::PH_W-1:0]     phase;
    logic                         transient;
    logic                         last;
  } request_t;

  typedef struct packed {
    logic [pvp_pkg::BIN_W-1:0] bin;
    logic [pvp_pkg::MAG_W-1:0] magnitude;
    logic [pvp_pkg::PH_W-1:0]  phase;
    logic                      channel;
  } synth_bin_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic cmd = 1'b0, channel = 1'b0, transient = 1'b0, last = 1'b0;
  logic [pvp_pkg::BIN_W-1:0] bin_index = '0;
  logic [pvp_pkg::MAG_W-1:0] magnitude = '0;
  logic [pvp_pkg::PH_W-1:0] phase = '0;
  logic out_valid, out_stall = 1'b0, out_channel;
  logic [pvp_pkg::BIN_W-1:0] out_bin;
  logic [pvp_pkg::MAG_W-1:0] out_magnitude;
  logic [pvp_pkg::PH_W-1:0] out_phase;
  logic cfg_we = 1'b0;
  logic [pvp_pkg::CFG_IDX_W-1:0] cfg_index = pvp_pkg::CFG_HOP;
  logic [pvp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  phase_locked_vocoder_phase_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .channel_i(channel), .bin_index_i(bin_index),
    .magnitude_i(magnitude), .phase_i(phase), .transient_i(transient), .last_i(last),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_bin_o(out_bin), .out_magnitude_o(out_magnitude),
    .out_phase_o(out_phase), .out_channel_o(out_channel),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [pvp_pkg::HOP_W-1:0]  hop = pvp_pkg::HOP_RST;
  logic [pvp_pkg::GAIN_W-1:0] gain = pvp_pkg::GAIN_RST;
  logic [pvp_pkg::BIN_W-1:0]  cutoff = pvp_pkg::CUTOFF_RST;
  logic [pvp_pkg::PH_W-1:0]   prev_ph [NBINS];
  logic [pvp_pkg::PH_W-1:0]   synth_ph [NBINS];
  logic [pvp_pkg::PH_W-1:0]   cur_ph [NBINS];
  logic [pvp_pkg::MAG_W-1:0]  cur_mag [NBINS];
  int unsigned                peak_of [NBINS];
  int unsigned                load_cnt = 0;

  request_t   pending_q[$];
  synth_bin_t expected_q[$];
  int errors = 0, n_checked = 0, n_frames = 0, n_accepted = 0;
  int gen_cnt = 0, written = 0;
  bit no_idle = 1'b0, hold_armed = 1'b0;

  initial begin
    for (int i = 0; i < NBINS; i++) begin
      prev_ph[i] = '0; synth_ph[i] = '0; cur_ph[i] = '0; cur_mag[i] = '0;
    end
  end

  function automatic int unsigned gap(int unsigned a, int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic logic [pvp_pkg::PH_W-1:0] inst_freq(int unsigned i);
    bit [63:0] ex, raw, dv, inst, prod;
    ex   = (64'(hop) * 64'(i)) << 18;
    raw  = 64'(pvp_pkg::PH_W'(cur_ph[i] - prev_ph[i])) << 16;
    dv   = (raw - ex) & 64'hFFFF_FFFF;
    inst = (dv >= 64'h8000_0000) ? ex + dv - 64'h1_0000_0000 : ex + dv;
    prod = inst * 64'(gain) + 64'h8000_0000;
    return prod[47:32];
  endfunction

  task automatic close_frame(int unsigned n, logic trans);
    int unsigned pk [$];
    int unsigned k;
    logic [pvp_pkg::PH_W-1:0] om [];
    logic [pvp_pkg::PH_W-1:0] psi [];
    om = new[n]; psi = new[n];
    k = 0;
    for (int unsigned i = 1; i + 1 < n; i++)
      if (cur_mag[i] > cur_mag[i-1] && cur_mag[i] > cur_mag[i+1]) pk.push_back(i);
    for (int unsigned i = 0; i < n; i++) begin
      if (pk.size() == 0) begin
        peak_of[i] = i;
      end else begin
        while (k + 1 < pk.size() && gap(i, pk[k+1]) < gap(i, pk[k])) k++;
        peak_of[i] = pk[k];
      end
    end
    for (int unsigned i = 0; i < n; i++) om[i] = inst_freq(i);
    if (trans) begin
      for (int unsigned i = 0; i < n; i++) synth_ph[i] = cur_ph[i];
    end else begin
      for (int unsigned i = 0; i < n; i++)
        psi[i] = synth_ph[peak_of[i]] + om[peak_of[i]] + cur_ph[i] - cur_ph[peak_of[i]];
      for (int unsigned i = 0; i < n; i++) synth_ph[i] = psi[i];
    end
    for (int unsigned i = 0; i < n; i++) prev_ph[i] = cur_ph[i];
    n_frames++;
  endtask

  task automatic predict(request_t r);
    synth_bin_t e;
    if (r.cmd == pvp_pkg::CMD_READ) begin
      if (r.bin_index < NBINS) begin
        e.bin = r.bin_index;
        e.magnitude = (r.bin_index > cutoff) ? '0 : cur_mag[r.bin_index];
        e.phase = synth_ph[r.bin_index];
        e.channel = 1'b0;
        expected_q.push_back(e);
      end
    end else if (r.channel == 1'b0) begin
      if (load_cnt < NBINS) begin
        cur_mag[load_cnt] = r.magnitude;
        cur_ph[load_cnt] = r.phase;
        load_cnt++;
      end
      if (r.last) begin
        close_frame(load_cnt, r.transient);
        load_cnt = 0;
      end
    end else begin
      if (load_cnt < NBINS) begin
        e.bin = pvp_pkg::BIN_W'(load_cnt);
        e.magnitude = (load_cnt > cutoff) ? '0 : r.magnitude;
        e.phase = synth_ph[load_cnt] + r.phase - cur_ph[load_cnt];
        e.channel = r.channel;
        expected_q.push_back(e);
        load_cnt++;
      end
      if (r.last) load_cnt = 0;
    end
  endtask

  // driver
  int unsigned idle_cnt = 0;
  always @(posedge clk_i) begin
    request_t r;
    logic nv;
    nv = in_valid;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        predict({cmd, channel, bin_index, magnitude, phase, transient, last});
        n_accepted++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (idle_cnt > 0) begin
          idle_cnt--;
        end else if (pending_q.size() > 0) begin
          r = pending_q.pop_front();
          cmd <= r.cmd; channel <= r.channel; bin_index <= r.bin_index;
          magnitude <= r.magnitude; phase <= r.phase;
          transient <= r.transient; last <= r.last;
          nv = 1'b1;
          if (!no_idle)
            idle_cnt = ($urandom_range(0, 9) < 6) ? 0 :
                       ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
      end
    end
    in_valid <= nv;
  end

  // receiver with random stalls and one long hold-off
  int unsigned stall_cnt = 0, hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    synth_bin_t e;
    if (out_valid && !out_stall && rst_ni) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result bin %0d", out_bin);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (out_bin !== e.bin) begin
          $error("out_bin expected %0d actual %0d", e.bin, out_bin); errors++;
        end
        if (out_magnitude !== e.magnitude) begin
          $error("out_magnitude expected %0h actual %0h", e.magnitude, out_magnitude); errors++;
        end
        if (out_phase !== e.phase) begin
          $error("out_phase expected %0h actual %0h", e.phase, out_phase); errors++;
        end
        if (out_channel !== e.channel) begin
          $error("out_channel expected %0d actual %0d", e.channel, out_channel); errors++;
        end
      end
    end
    if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 9) < 3) begin
      stall_cnt = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // stimulus side mirrors the shared bin counter so that no unwritten entry is read
  task automatic add(logic c, logic ch, logic [pvp_pkg::BIN_W-1:0] b,
                     logic [pvp_pkg::MAG_W-1:0] m, logic [pvp_pkg::PH_W-1:0] p,
                     logic tr, logic l);
    pending_q.push_back('{c, ch, b, m, p, tr, l});
    if (c == pvp_pkg::CMD_LOAD) begin
      if (gen_cnt < NBINS) begin
        if (ch == 1'b0 && gen_cnt + 1 > written) written = gen_cnt + 1;
        gen_cnt++;
      end
      if (l) gen_cnt = 0;
    end
  endtask

  task automatic add_read();
    if ($urandom_range(0, 9) == 0 || written == 0)
      add(pvp_pkg::CMD_READ, 1'($urandom), 14'($urandom_range(NBINS, 16383)),
          24'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
    else
      add(pvp_pkg::CMD_READ, 1'($urandom), 14'($urandom_range(0, written - 1)),
          24'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // all requests taken, block idle and every result checked
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid || in_stall || out_valid ||
           expected_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic drain_and_write(logic [pvp_pkg::CFG_IDX_W-1:0] idx,
                                 logic [pvp_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    @(posedge clk_i);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      pvp_pkg::CFG_HOP:  hop = val[pvp_pkg::HOP_W-1:0];
      pvp_pkg::CFG_GAIN: gain = val;
      default:           cutoff = val[pvp_pkg::BIN_W-1:0];
    endcase
  endtask

  task automatic random_frames(int n_items);
    int target, len;
    bit tr;
    target = pending_q.size() + n_items;
    while (pending_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 40);
          tr = ($urandom_range(0, 4) == 0);
          for (int i = 0; i < len; i++)
            add(pvp_pkg::CMD_LOAD, 1'b0, 14'($urandom), 24'($urandom), 16'($urandom),
                tr, i == len - 1);
        end
        4, 5, 6: repeat ($urandom_range(1, 8)) add_read();
        7, 8: begin
          if (written > gen_cnt) begin
            len = $urandom_range(1, written - gen_cnt);
            for (int i = 0; i < len; i++)
              add(pvp_pkg::CMD_LOAD, 1'b1, 14'($urandom), 24'($urandom), 16'($urandom),
                  1'($urandom), i == len - 1);
          end
        end
        default: begin
          // broken sequences: a few loads left open, or a stray channel-1 close
          if ($urandom_range(0, 1) && gen_cnt < written)
            add(pvp_pkg::CMD_LOAD, 1'b1, 14'($urandom), 24'($urandom), 16'($urandom),
                1'($urandom), 1'b1);
          else
            repeat ($urandom_range(1, 4))
              add(pvp_pkg::CMD_LOAD, 1'b0, 14'($urandom), 24'($urandom), 16'($urandom),
                  1'($urandom), 1'b0);
        end
      endcase
    end
  endtask

  initial begin
    logic [pvp_pkg::MAG_W-1:0] mags [12] = '{24'h0, 24'h10, 24'h5, 24'h5, 24'h5, 24'h20,
                                             24'hFFFFFF, 24'h7, 24'h7, 24'h30, 24'h2,
                                             24'h0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: peaks, plateaus, field extremes
    for (int i = 0; i < 12; i++)
      add(pvp_pkg::CMD_LOAD, 1'b0, 14'(i), mags[i], (i % 2) ? 16'hFFFF : 16'h0, 1'b0,
          i == 11);
    for (int i = 0; i < 12; i += 3) add(pvp_pkg::CMD_READ, 1'b0, 14'(i), '0, '0, 1'b0, 1'b0);
    add(pvp_pkg::CMD_READ, 1'b1, 14'(NBINS), '1, '1, 1'b1, 1'b1);
    add(pvp_pkg::CMD_READ, 1'b0, 14'h3FFF, '0, '0, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++)
      add(pvp_pkg::CMD_LOAD, 1'b1, '1, (i == 0) ? 24'hFFFFFF : 24'h0, 16'(i * 16'h5555),
          1'b0, i == 3);
    // flat frame with no peak, then a transient frame
    for (int i = 0; i < 3; i++)
      add(pvp_pkg::CMD_LOAD, 1'b0, '0, 24'h40, 16'h1234, 1'b0, i == 2);
    for (int i = 0; i < 3; i++)
      add(pvp_pkg::CMD_LOAD, 1'b0, '0, 24'(i), 16'hABCD, 1'b1, i == 2);
    add(pvp_pkg::CMD_READ, 1'b0, 14'd1, '0, '0, 1'b0, 1'b0);
    random_frames(50);

    drain_and_write(pvp_pkg::CFG_HOP, 32'd1);
    drain_and_write(pvp_pkg::CFG_GAIN, 32'd0);
    drain_and_write(pvp_pkg::CFG_CUTOFF, 32'd0);
    random_frames(50);

    drain_and_write(pvp_pkg::CFG_HOP, 32'd16384);
    drain_and_write(pvp_pkg::CFG_GAIN, 32'hFFFF_FFFF);
    drain_and_write(pvp_pkg::CFG_CUTOFF, 32'd8192);
    // back-to-back frame and matching channel-1 loads with no gaps
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++)
      add(pvp_pkg::CMD_LOAD, 1'b0, '0, 24'($urandom), 16'($urandom), 1'b0, i == 39);
    for (int i = 0; i < 40; i++)
      add(pvp_pkg::CMD_LOAD, 1'b1, '0, 24'($urandom), 16'($urandom), 1'b0, i == 39);
    add(pvp_pkg::CMD_READ, 1'b0, 14'd39, '0, '0, 1'b0, 1'b0);
    add(pvp_pkg::CMD_READ, 1'b0, 14'd0, '0, '0, 1'b0, 1'b0);
    drain_and_write(pvp_pkg::CFG_CUTOFF, 32'd20);
    no_idle = 1'b0;
    repeat (30) add_read();
    random_frames(50);

    for (int ph = 0; ph < 3; ph++) begin
      drain_and_write(pvp_pkg::CFG_HOP, 32'($urandom_range(1, 16384)));
      drain_and_write(pvp_pkg::CFG_GAIN, $urandom);
      drain_and_write(pvp_pkg::CFG_CUTOFF, 32'($urandom_range(0, 8192)));
      if (ph == 1) begin
        hold_armed = 1'b1;
        repeat (40) add_read();
      end
      random_frames(50);
    end

    wait_idle();
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
    end
    $display("covered %0d accepted requests, %0d closed frames, %0d checked results",
             n_accepted, n_frames, n_checked);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #30000000;
    $display("timeout waiting for the block");
    $display("Regression FAIL");
    $finish;
  end

endmodule
